// ===== hdl/pdrtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdrtd_pkg;

  localparam int TRACK_BYTES_DEF = 1024;
  localparam int FIDX_W = 14;
  localparam int VAL_W = 16;
  localparam int PC_W = 5;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  localparam logic [1:0] MODE_HDR = 2'd0;
  localparam logic [1:0] MODE_LIT = 2'd1;
  localparam logic [1:0] MODE_REP = 2'd2;

  localparam logic CFG_FIELD_WIDTH = 1'b0;
  localparam logic CFG_VALUE_MASK  = 1'b1;

  localparam logic [4:0] WIDTH_MIN = 5'd6;
  localparam logic [4:0] WIDTH_MAX = 5'd16;
  localparam logic [4:0] WIDTH_RST = 5'd8;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_MLOAD,
    UOP_POS,
    UOP_Q,
    UOP_R,
    UOP_FIX,
    UOP_WR,
    UOP_RD,
    UOP_RDC,
    UOP_CAP,
    UOP_EXT,
    UOP_HDR,
    UOP_SETSHORT,
    UOP_SETCNT,
    UOP_SETLONG,
    UOP_SETLIT,
    UOP_LITOUT,
    UOP_REPOUT
  } uop_t;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_BR,
    SEQ_CALL,
    SEQ_RET,
    SEQ_DONE
  } seq_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_MODE0,
    COND_MODE2,
    COND_FLD5,
    COND_FLD4
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    seq_t            seq;
    cond_t           cond;
    logic [1:0]      koff;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_L0   = 5'd0;
  localparam logic [PC_W-1:0] PC_L1   = 5'd1;
  localparam logic [PC_W-1:0] PC_L2   = 5'd2;
  localparam logic [PC_W-1:0] PC_L3   = 5'd3;
  localparam logic [PC_W-1:0] PC_L4   = 5'd4;
  localparam logic [PC_W-1:0] PC_D0   = 5'd5;
  localparam logic [PC_W-1:0] PC_D1   = 5'd6;
  localparam logic [PC_W-1:0] PC_D2   = 5'd7;
  localparam logic [PC_W-1:0] PC_D3   = 5'd8;
  localparam logic [PC_W-1:0] PC_H0   = 5'd9;
  localparam logic [PC_W-1:0] PC_H1   = 5'd10;
  localparam logic [PC_W-1:0] PC_H2   = 5'd11;
  localparam logic [PC_W-1:0] PC_HS0  = 5'd12;
  localparam logic [PC_W-1:0] PC_HS1  = 5'd13;
  localparam logic [PC_W-1:0] PC_HG0  = 5'd14;
  localparam logic [PC_W-1:0] PC_HG1  = 5'd15;
  localparam logic [PC_W-1:0] PC_HG2  = 5'd16;
  localparam logic [PC_W-1:0] PC_HG3  = 5'd17;
  localparam logic [PC_W-1:0] PC_HL   = 5'd18;
  localparam logic [PC_W-1:0] PC_REP  = 5'd19;
  localparam logic [PC_W-1:0] PC_FLD  = 5'd20;
  localparam logic [PC_W-1:0] PC_FLD1 = 5'd21;
  localparam logic [PC_W-1:0] PC_FLD2 = 5'd22;
  localparam logic [PC_W-1:0] PC_FLD3 = 5'd23;
  localparam logic [PC_W-1:0] PC_FLD4 = 5'd24;
  localparam logic [PC_W-1:0] PC_FLD5 = 5'd25;
  localparam logic [PC_W-1:0] PC_FLD6 = 5'd26;
  localparam logic [PC_W-1:0] PC_FLD7 = 5'd27;

  function automatic ucode_t cw(input uop_t u, input seq_t s, input cond_t c,
                                input logic [1:0] k, input logic [PC_W-1:0] t);
    ucode_t w;
    w.uop = u;
    w.seq = s;
    w.cond = c;
    w.koff = k;
    w.target = t;
    return w;
  endfunction

  // Control store. The field read routine at PC_FLD is entered by CALL from
  // a word that has already latched the bit position of the wanted field.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_L0:   w = cw(UOP_MLOAD,    SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_L1:   w = cw(UOP_Q,        SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_L2:   w = cw(UOP_R,        SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_L3:   w = cw(UOP_FIX,      SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_L4:   w = cw(UOP_WR,       SEQ_DONE, COND_NONE,  2'd0, PC_L0);
      PC_D0:   w = cw(UOP_NONE,     SEQ_BR,   COND_MODE0, 2'd0, PC_H0);
      PC_D1:   w = cw(UOP_NONE,     SEQ_BR,   COND_MODE2, 2'd0, PC_REP);
      PC_D2:   w = cw(UOP_POS,      SEQ_CALL, COND_NONE,  2'd0, PC_FLD);
      PC_D3:   w = cw(UOP_LITOUT,   SEQ_DONE, COND_NONE,  2'd0, PC_L0);
      PC_H0:   w = cw(UOP_POS,      SEQ_CALL, COND_NONE,  2'd0, PC_FLD);
      PC_H1:   w = cw(UOP_HDR,      SEQ_BR,   COND_FLD5,  2'd0, PC_HL);
      PC_H2:   w = cw(UOP_NONE,     SEQ_BR,   COND_FLD4,  2'd0, PC_HG0);
      PC_HS0:  w = cw(UOP_POS,      SEQ_CALL, COND_NONE,  2'd1, PC_FLD);
      PC_HS1:  w = cw(UOP_SETSHORT, SEQ_JUMP, COND_NONE,  2'd0, PC_REP);
      PC_HG0:  w = cw(UOP_POS,      SEQ_CALL, COND_NONE,  2'd1, PC_FLD);
      PC_HG1:  w = cw(UOP_SETCNT,   SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_HG2:  w = cw(UOP_POS,      SEQ_CALL, COND_NONE,  2'd2, PC_FLD);
      PC_HG3:  w = cw(UOP_SETLONG,  SEQ_JUMP, COND_NONE,  2'd0, PC_REP);
      PC_HL:   w = cw(UOP_SETLIT,   SEQ_JUMP, COND_NONE,  2'd0, PC_D2);
      PC_REP:  w = cw(UOP_REPOUT,   SEQ_DONE, COND_NONE,  2'd0, PC_L0);
      PC_FLD:  w = cw(UOP_Q,        SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD1: w = cw(UOP_R,        SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD2: w = cw(UOP_FIX,      SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD3: w = cw(UOP_RD,       SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD4: w = cw(UOP_RDC,      SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD5: w = cw(UOP_RDC,      SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD6: w = cw(UOP_CAP,      SEQ_NEXT, COND_NONE,  2'd0, PC_L0);
      PC_FLD7: w = cw(UOP_EXT,      SEQ_RET,  COND_NONE,  2'd0, PC_L0);
      default: w = cw(UOP_NONE,     SEQ_DONE, COND_NONE,  2'd0, PC_L0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pdrtd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdrtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/packed_delta_rle_track_decoder.sv =====
// Load item: address reduction, then one write to the track memory; start and unused items
// need no sequencing. Step item: a repeat run only emits, a literal run reads one packed
// field, a header decode reads two or three; each packed field read costs 8 microcode steps
// (address reduction, three byte reads from the single track memory port).
// One item at a time; a finished result waits in the output register while the next
// item is accepted. Sync reset clears decoder state and config (width 8, mask 0xFFFF);
// track memory contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module packed_delta_rle_track_decoder #(
  parameter int TRACK_BYTES = pdrtd_pkg::TRACK_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [9:0]         byte_address,
  input  wire logic [7:0]         byte_data,
  input  wire logic [15:0]        start_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      delta,
  output logic [15:0]             running_value,
  output logic [1:0]              run_kind
);

  import pdrtd_pkg::*;

  localparam int AW = $clog2(TRACK_BYTES);
  localparam logic [26:0] RECIP = 27'((64'd1 << 32) / TRACK_BYTES);
  localparam logic [17:0] TB = 18'(TRACK_BYTES);
  localparam logic [AW-1:0] LAST = AW'(TRACK_BYTES - 1);

  logic [4:0]        field_width;
  logic [VAL_W-1:0]  value_mask;

  logic              busy;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   ret;
  ucode_t            ctl;

  logic [FIDX_W-1:0] fidx;
  logic [VAL_W-1:0]  rcount;
  logic [VAL_W-1:0]  rval;
  logic [1:0]        mode;
  logic [VAL_W-1:0]  acc;

  logic [9:0]        ld_addr;
  logic [7:0]        ld_data;
  logic [15:0]       mval;
  logic [2:0]        sh;
  logic [15:0]       q;
  logic [17:0]       rem;
  logic [AW-1:0]     maddr;
  logic [23:0]       word;
  logic [15:0]       fld;
  logic [3:0]        hdr;

  logic [4:0]        weff;
  logic [FIDX_W-1:0] pidx;
  logic [18:0]       bpos;
  logic [42:0]       qprod;
  logic [33:0]       qt;
  logic [17:0]       rem_fix;
  logic [23:0]       shifted;
  logic [4:0]        sign_pos;
  logic [15:0]       ext;
  logic              emit;
  logic              stall;
  logic              advance;
  logic              cond_true;
  logic [VAL_W-1:0]  emit_delta;
  logic [VAL_W-1:0]  rc_dec;
  logic [1:0]        mode_after;
  logic              accept;
  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  assign ctl = ucode(pc);
  assign in_ready = !busy;
  assign accept = in_valid && in_ready;

  always_comb begin
    weff = field_width;
    if (field_width < WIDTH_MIN) begin
      weff = WIDTH_MIN;
    end else if (field_width > WIDTH_MAX) begin
      weff = WIDTH_MAX;
    end
  end

  assign pidx = fidx + FIDX_W'(ctl.koff);
  assign bpos = 19'(pidx) * 19'(weff);
  assign qprod = 43'(mval) * 43'(RECIP);
  assign qt = 34'(q) * 34'(TRACK_BYTES);
  assign rem_fix = (rem >= TB) ? rem - TB : rem;

  assign shifted = word >> sh;
  assign sign_pos = weff - 5'd1;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ext[i] = (i < int'(weff)) ? shifted[i] : shifted[sign_pos];
    end
  end

  always_comb begin
    case (ctl.cond)
      COND_MODE0: cond_true = (mode == MODE_HDR);
      COND_MODE2: cond_true = (mode == MODE_REP);
      COND_FLD5:  cond_true = fld[5];
      COND_FLD4:  cond_true = fld[4];
      default:    cond_true = 1'b0;
    endcase
  end

  assign emit = (ctl.uop == UOP_LITOUT) || (ctl.uop == UOP_REPOUT);
  assign stall = emit && out_valid && !out_ready;
  assign advance = busy && !stall;

  assign emit_delta = (ctl.uop == UOP_REPOUT) ? rval : fld;
  assign rc_dec = rcount - 16'd1;
  always_comb begin
    if (rc_dec == '0) begin
      mode_after = MODE_HDR;
    end else if (ctl.uop == UOP_REPOUT) begin
      mode_after = MODE_REP;
    end else begin
      mode_after = MODE_LIT;
    end
  end

  assign ram_we = advance && (ctl.uop == UOP_WR);
  assign ram_re = advance && ((ctl.uop == UOP_RD) || (ctl.uop == UOP_RDC));

  pdrtd_ram #(
    .WIDTH(8),
    .DEPTH(TRACK_BYTES)
  ) u_track_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (maddr),
    .wdata(ld_data),
    .rdata(ram_rdata)
  );

  // Sequencer and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= WIDTH_RST;
      value_mask <= '1;
      busy <= 1'b0;
      pc <= PC_L0;
      ret <= PC_L0;
      fidx <= '0;
      rcount <= '0;
      rval <= '0;
      mode <= MODE_HDR;
      acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIELD_WIDTH: field_width <= cfg_data[4:0];
          CFG_VALUE_MASK:  value_mask <= cfg_data;
          default: ;
        endcase
      end

      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        case (func)
          FUNC_LOAD: begin
            busy <= 1'b1;
            pc <= PC_L0;
          end
          FUNC_START: begin
            fidx <= '0;
            rcount <= '0;
            rval <= '0;
            mode <= MODE_HDR;
            acc <= start_value;
          end
          FUNC_STEP: begin
            busy <= 1'b1;
            pc <= PC_D0;
          end
          default: ;
        endcase
      end

      if (advance) begin
        case (ctl.seq)
          SEQ_NEXT: pc <= pc + 1'b1;
          SEQ_JUMP: pc <= ctl.target;
          SEQ_BR:   pc <= cond_true ? ctl.target : pc + 1'b1;
          SEQ_CALL: begin
            ret <= pc + 1'b1;
            pc <= ctl.target;
          end
          SEQ_RET:  pc <= ret;
          SEQ_DONE: busy <= 1'b0;
          default:  busy <= 1'b0;
        endcase

        case (ctl.uop)
          UOP_SETSHORT: begin
            rval <= fld;
            rcount <= {13'd0, hdr[2:0]};
            fidx <= fidx + 14'd2;
            mode <= MODE_REP;
          end
          UOP_SETCNT: rcount <= {8'd0, hdr[2:0], fld[4:0]};
          UOP_SETLONG: begin
            rval <= fld;
            fidx <= fidx + 14'd3;
            mode <= MODE_REP;
          end
          UOP_SETLIT: begin
            rcount <= (hdr == 4'd0) ? 16'd16 : {12'd0, hdr};
            fidx <= fidx + 14'd1;
            mode <= MODE_LIT;
          end
          UOP_LITOUT, UOP_REPOUT: begin
            if (ctl.uop == UOP_LITOUT) begin
              fidx <= fidx + 14'd1;
            end
            rcount <= rc_dec;
            mode <= mode_after;
            acc <= (acc + emit_delta) & value_mask;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ld_addr <= byte_address;
      ld_data <= byte_data;
    end
    if (advance) begin
      case (ctl.uop)
        UOP_MLOAD: mval <= {6'd0, ld_addr};
        UOP_POS: begin
          mval <= bpos[18:3];
          sh <= bpos[2:0];
        end
        UOP_Q:   q <= 16'(qprod >> 32);
        UOP_R:   rem <= {2'b00, mval} - qt[17:0];
        UOP_FIX: maddr <= rem_fix[AW-1:0];
        UOP_RD:  maddr <= (maddr == LAST) ? '0 : maddr + 1'b1;
        UOP_RDC: begin
          maddr <= (maddr == LAST) ? '0 : maddr + 1'b1;
          word <= {ram_rdata, word[23:8]};
        end
        UOP_CAP: word <= {ram_rdata, word[23:8]};
        UOP_EXT: fld <= ext;
        UOP_HDR: hdr <= fld[3:0];
        UOP_LITOUT, UOP_REPOUT: begin
          delta <= signed'(emit_delta);
          running_value <= (acc + emit_delta) & value_mask;
          run_kind <= mode_after;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && ($past(pc) == PC_D3 || $past(pc) == PC_REP))
    else $error("result raised outside an output step");

  a_step_entry: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_STEP |=> busy && pc == PC_D0)
    else $error("step item did not enter decode");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    advance && ctl.uop == UOP_R |=> rem < {TB[16:0], 1'b0})
    else $error("address reduction out of range");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    advance && (ctl.uop == UOP_FIX || ctl.uop == UOP_RD) |=> 32'(maddr) < TRACK_BYTES)
    else $error("track address beyond memory");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_kind != 2'd3)
    else $error("illegal run kind reported");
`endif

endmodule

`default_nettype wire

// ===== dv/packed_delta_rle_track_decoder_tb.sv =====
`timescale 1ns / 1ps

module packed_delta_rle_track_decoder_tb;
  import pdrtd_pkg::*;

  localparam int MEM_BYTES = TRACK_BYTES_DEF;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int ITEM_GOAL = 1250;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int WRAP_STEPS = 500;
  localparam int LIT_SPAN_BYTES = 34;  // literal run of 16 at width 16: 17 fields

  typedef struct {
    logic signed [15:0] delta;
    logic [15:0]        total;
    logic [1:0]         mode;
  } frame_t;

  class track_scoreboard;
    bit [7:0]  mem [MEM_BYTES];
    bit [4:0]  width_reg = WIDTH_RST;
    bit [15:0] mask_reg = 16'hFFFF;
    bit [13:0] fidx;
    bit [15:0] cnt;
    bit [15:0] rep_val;
    bit [15:0] acc;
    bit [1:0]  mode = MODE_HDR;
    frame_t    frame_q[$];
    int        errors;
    int        frames_seen;

    function int unsigned eff_w();
      if (width_reg < WIDTH_MIN) return WIDTH_MIN;
      if (width_reg > WIDTH_MAX) return WIDTH_MAX;
      return width_reg;
    endfunction

    // packed field, sign-extended to 16 bits
    function bit [15:0] field_at(input bit [13:0] idx);
      int unsigned w, pos, base;
      bit [31:0] word, m, v;
      w = eff_w();
      pos = idx * w;
      base = pos >> 3;
      word = {mem[(base + 3) % MEM_BYTES], mem[(base + 2) % MEM_BYTES],
              mem[(base + 1) % MEM_BYTES], mem[base % MEM_BYTES]};
      m = (32'd1 << w) - 32'd1;
      v = (word >> (pos & 7)) & m;
      if (v[w - 1]) v = v | ~m;
      return v[15:0];
    endfunction

    function bit [15:0] next_delta();
      bit [15:0] hdr, lo_f, v;
      if (mode == MODE_HDR) begin
        hdr = field_at(fidx);
        if (!hdr[5]) begin
          mode = MODE_REP;
          if (hdr[4]) begin
            lo_f = field_at(fidx + 14'd1);
            cnt = {8'd0, hdr[2:0], lo_f[4:0]};
            rep_val = field_at(fidx + 14'd2);
            fidx = fidx + 14'd3;
          end else begin
            rep_val = field_at(fidx + 14'd1);
            cnt = {13'd0, hdr[2:0]};
            fidx = fidx + 14'd2;
          end
        end else begin
          cnt = (hdr[3:0] == 4'd0) ? 16'd16 : {12'd0, hdr[3:0]};
          mode = MODE_LIT;
          fidx = fidx + 14'd1;
        end
      end
      if (mode == MODE_REP) begin
        cnt = cnt - 16'd1;
        if (cnt == 16'd0) mode = MODE_HDR;
        return rep_val;
      end
      v = field_at(fidx);
      cnt = cnt - 16'd1;
      fidx = fidx + 14'd1;
      if (cnt == 16'd0) mode = MODE_HDR;
      return v;
    endfunction

    function void note_item(input bit [1:0] f, input bit [9:0] a, input bit [7:0] d,
                            input bit [15:0] k);
      frame_t fr;
      bit [15:0] dl;
      case (f)
        FUNC_LOAD: mem[a] = d;
        FUNC_START: begin
          fidx = '0;
          cnt = '0;
          rep_val = '0;
          mode = MODE_HDR;
          acc = k;
        end
        FUNC_STEP: begin
          dl = next_delta();
          acc = (acc + dl) & mask_reg;
          fr.delta = dl;
          fr.total = acc;
          fr.mode = mode;
          frame_q.push_back(fr);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return frame_q.size();
    endfunction

    task report(input string msg);
      errors++;
      $display("ERROR %s", msg);
    endtask

    task check_result(input logic signed [15:0] d, input logic [15:0] v,
                      input logic [1:0] k);
      frame_t e;
      if (frame_q.size() == 0) begin
        report($sformatf("unexpected result delta %0d value %h kind %0d", d, v, k));
        return;
      end
      e = frame_q.pop_front();
      if (d !== e.delta || v !== e.total || k !== e.mode)
        report($sformatf("frame %0d: delta %0d exp %0d, value %h exp %h, kind %0d exp %0d",
                         frames_seen, d, e.delta, v, e.total, k, e.mode));
      frames_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FUNC_LOAD;
  logic [9:0] byte_address = '0;
  logic [7:0] byte_data = '0;
  logic [15:0] start_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] delta;
  logic [15:0] running_value;
  logic [1:0] run_kind;

  track_scoreboard sb = new;
  bit [15:0] track_fields[$];
  int track_frames;
  int items_sent;
  int cycle_cnt;
  bit calm;
  bit hold_req;

  packed_delta_rle_track_decoder i_dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(delta, running_value, run_kind);
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic push_item(input logic [1:0] f, input logic [9:0] a, input logic [7:0] d,
                           input logic [15:0] k);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    byte_address <= a;
    byte_data <= d;
    start_value <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(f, a, d, k);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_func(input logic [1:0] f);
    push_item(f, 10'($urandom()), 8'($urandom()), 16'($urandom()));
  endtask

  task automatic run_frames(input int n, input bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: push_func(FUNC_NONE);
          1: push_func(FUNC_LOAD);
          default: push_func(FUNC_START);
        endcase
      end
      push_func(FUNC_STEP);
    end
  endtask

  // pack track_fields from field 0 at the current width, keep bits past the end
  task automatic load_track();
    bit [7:0] img [256];
    int unsigned w, nbytes, p;
    w = sb.eff_w();
    nbytes = (track_fields.size() * w + 7) / 8;
    for (int i = 0; i < nbytes; i++) img[i] = sb.mem[i];
    foreach (track_fields[i]) begin
      for (int b = 0; b < w; b++) begin
        p = i * w + b;
        img[p >> 3][p & 7] = track_fields[i][b];
      end
    end
    for (int i = 0; i < nbytes; i++) push_item(FUNC_LOAD, 10'(i), img[i], 16'($urandom()));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_config(input bit [4:0] w, input bit [15:0] m);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIELD_WIDTH;
    cfg_data <= {11'($urandom()), w};
    @(negedge clk);
    cfg_index <= CFG_VALUE_MASK;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.width_reg = w;
    sb.mask_reg = m;
  endtask

  initial begin
    int base, n, hi, lo, n_steps, phase, cfg_round;
    bit [4:0] nw;
    bit [15:0] nm;
    bit [7:0] hb;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // preload whole memory: literal runs of 16 when read at width 16
    for (int i = 0; i < MEM_BYTES; i++)
      push_item(FUNC_LOAD, 10'(i),
                (i % LIT_SPAN_BYTES == 0) ? ((8'($urandom()) & 8'hD0) | 8'h20)
                                          : 8'($urandom()),
                16'($urandom()));

    // directed, width 8
    push_item(FUNC_NONE, 10'h3FF, 8'hFF, 16'hFFFF);
    track_fields = '{16'h0000, 16'h007F};  // repeat with count 0
    load_track();
    push_item(FUNC_START, 10'h000, 8'h00, 16'hFFFF);
    repeat (3) push_func(FUNC_STEP);
    // literal 1, long repeat 2, short repeat 1
    track_fields = '{16'h0021, 16'h0080, 16'h0010, 16'h0002, 16'h007F, 16'h0001, 16'h00FF};
    load_track();
    push_item(FUNC_START, 10'h3FF, 8'hFF, 16'h0000);
    repeat (5) push_func(FUNC_STEP);

    base = items_sent;

    // full pass over memory at width 16, across the address wrap
    apply_config(WIDTH_MAX, 16'($urandom()));
    for (int j = 0; j * LIT_SPAN_BYTES < MEM_BYTES; j++) begin
      hb = sb.mem[j * LIT_SPAN_BYTES];
      if ((hb & 8'h2F) != 8'h20)
        push_item(FUNC_LOAD, 10'(j * LIT_SPAN_BYTES), (hb & 8'hD0) | 8'h20,
                  16'($urandom()));
    end
    push_func(FUNC_START);
    hold_req = 1'b1;
    run_frames(WRAP_STEPS, 1'b0);

    phase = 0;
    cfg_round = 0;
    while (items_sent - base < ITEM_GOAL) begin
      calm = (items_sent - base) > ITEM_GOAL * 17 / 20;
      if (phase % 2 == 1) begin
        case (cfg_round)
          0: begin
            nw = WIDTH_MIN;
            nm = 16'h0000;
          end
          1: begin
            nw = 5'($urandom_range(0, 5));
            nm = 16'($urandom());
          end
          2: begin
            nw = 5'($urandom_range(17, 31));
            nm = 16'hFFFF;
          end
          default: begin
            nw = ($urandom_range(0, 4) == 0) ? 5'($urandom()) : 5'($urandom_range(6, 16));
            case ($urandom_range(0, 5))
              0: nm = 16'h0000;
              1, 2: nm = 16'hFFFF;
              default: nm = 16'($urandom());
            endcase
          end
        endcase
        apply_config(nw, nm);
        cfg_round++;
      end
      if ($urandom_range(0, 5) == 0) begin
        push_func(FUNC_START);
        run_frames($urandom_range(4, 24), 1'b1);
      end else begin
        track_fields = {};
        track_frames = 0;
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: begin
              n = $urandom_range(1, 16);
              track_fields.push_back((16'($urandom()) & 16'hFFD0) | 16'h0020 | 16'(n & 15));
              repeat (n) track_fields.push_back(16'($urandom()));
            end
            1: begin
              n = $urandom_range(1, 7);
              track_fields.push_back((16'($urandom()) & 16'hFFC8) | 16'(n));
              track_fields.push_back(16'($urandom()));
            end
            default: begin
              hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
              lo = (hi == 0) ? $urandom_range(1, 12) : $urandom_range(0, 31);
              n = (hi << 5) | lo;
              track_fields.push_back((16'($urandom()) & 16'hFFC8) | 16'h0010 | 16'(hi));
              track_fields.push_back((16'($urandom()) & 16'hFFE0) | 16'(lo));
              track_fields.push_back(16'($urandom()));
            end
          endcase
          track_frames += n;
        end
        load_track();
        push_func(FUNC_START);
        n_steps = track_frames + $urandom_range(0, 2);
        if (n_steps > 48) n_steps = 48;
        run_frames(n_steps, 1'b1);
      end
      phase++;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
